// ===== sv/alr_pkg.sv =====
// ----------------------------------------------------------------------------
// alr_pkg
// Shared constants and types for the anti-aliased line rasterizer.
// ----------------------------------------------------------------------------
package alr_pkg;

	localparam int COORD_BITS = 6;
	localparam int FRAC_BITS  = 16;

	localparam int IN_COORD_W = 6;
	localparam int PIX_A_W    = 6;
	localparam int PIX_B_W    = 7;
	localparam int LEVEL_W    = 8;

	// radix-4 restoring divide of (|dminor| << FRAC_BITS) by dmajor
	localparam int DIV_STEPS = (COORD_BITS + FRAC_BITS + 1) / 2;
	localparam int DIV_W     = 2 * DIV_STEPS;
	localparam int DCNT_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	// signed intercept accumulator
	localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;

	typedef struct packed {
		logic [IN_COORD_W-1:0] start_a;
		logic [IN_COORD_W-1:0] start_b;
		logic [IN_COORD_W-1:0] end_a;
		logic [IN_COORD_W-1:0] end_b;
		logic [LEVEL_W-1:0]    intensity;
	} req_t;

	typedef struct packed {
		logic [PIX_A_W-1:0] pixel_a;
		logic [PIX_B_W-1:0] pixel_b;
		logic               pair_along_a;
		logic [LEVEL_W-1:0] near_level;
		logic [LEVEL_W-1:0] far_level;
		logic               last;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIRST,
		ST_MID,
		ST_LAST
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic emit_first;
		logic emit_mid;
		logic emit_last;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic dx_small;
		logic mid_last;
	} sts_t;

endpackage

// ===== sv/alr_ctrl.sv =====
// ----------------------------------------------------------------------------
// alr_ctrl
// Sequencer: load, gradient divide, first endpoint, interior columns, end.
// ----------------------------------------------------------------------------
module alr_ctrl import alr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_nx = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_last) state_nx = ST_FIRST;
			end
			ST_FIRST: begin
				state_nx = sts.dx_small ? ST_LAST : ST_MID;
			end
			ST_MID: begin
				if (sts.mid_last) state_nx = ST_LAST;
			end
			ST_LAST: begin
				state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_DIV:   cmd.div_step   = 1'b1;
			ST_FIRST: cmd.emit_first = 1'b1;
			ST_MID:   cmd.emit_mid   = 1'b1;
			ST_LAST:  cmd.emit_last  = 1'b1;
			default:  busy           = 1'b1;
		endcase
	end

endmodule

// ===== sv/alr_dp.sv =====
// ----------------------------------------------------------------------------
// alr_dp
// Line setup, radix-4 gradient divider, intercept walk and result register.
// ----------------------------------------------------------------------------
module alr_dp import alr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  req_t request,
	input  cmd_t cmd,
	output sts_t sts,
	output res_t result,
	output logic result_valid
);

	localparam int C = COORD_BITS;
	localparam int F = FRAC_BITS;

	// setup
	logic [C-1:0] a0, b0, a1, b1, ada, adb, mj0, mn0, mj1, mn1;
	logic [C-1:0] x0c, y0c, x1c, y1c, ady;
	logic         steep, swap;

	// line registers
	logic [C-1:0]       x0_q, y0_q, x1_q, y1_q, dx_q, col_q;
	logic               steep_q, dyn_q;
	logic [LEVEL_W-1:0] inten_q;

	// divider
	logic [DIV_W-1:0]  num_q, quo_q;
	logic [C-1:0]      rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [C:0]        r1, r2, r1s, r2s;
	logic              ge1, ge2;

	// walk
	logic [ACC_W-1:0] acc_q, mag, grad;
	logic [C-1:0]     minor, major;
	logic [F-1:0]     frac;
	logic [F:0]       rfrac;
	logic [LEVEL_W+F:0]   near_prod;
	logic [LEVEL_W+F-1:0] far_prod;

	res_t res_q;
	logic valid_q;

	always_comb begin
		a0 = request.start_a[C-1:0];
		b0 = request.start_b[C-1:0];
		a1 = request.end_a[C-1:0];
		b1 = request.end_b[C-1:0];
		ada = (a1 >= a0) ? a1 - a0 : a0 - a1;
		adb = (b1 >= b0) ? b1 - b0 : b0 - b1;
		steep = adb > ada;
		mj0 = steep ? b0 : a0;
		mn0 = steep ? a0 : b0;
		mj1 = steep ? b1 : a1;
		mn1 = steep ? a1 : b1;
		swap = mj0 > mj1;
		x0c = swap ? mj1 : mj0;
		y0c = swap ? mn1 : mn0;
		x1c = swap ? mj0 : mj1;
		y1c = swap ? mn0 : mn1;
		ady = (y1c >= y0c) ? y1c - y0c : y0c - y1c;
	end

	always_comb begin
		r1  = {rem_q, num_q[DIV_W-1]};
		ge1 = r1 >= {1'b0, dx_q};
		r1s = ge1 ? r1 - {1'b0, dx_q} : r1;
		r2  = {r1s[C-1:0], num_q[DIV_W-2]};
		ge2 = r2 >= {1'b0, dx_q};
		r2s = ge2 ? r2 - {1'b0, dx_q} : r2;
	end

	always_comb begin
		mag   = ACC_W'(quo_q[F:0]);
		grad  = dyn_q ? ACC_W'(~mag + ACC_W'(1)) : mag;
		minor = acc_q[F+C-1:F];
		frac  = acc_q[F-1:0];
		major = x0_q + col_q;
		rfrac = (F+1)'(1) << F;
		rfrac = rfrac - {1'b0, frac};
		near_prod = inten_q * rfrac;
		far_prod  = inten_q * frac;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x0_q    <= x0c;
			y0_q    <= y0c;
			x1_q    <= x1c;
			y1_q    <= y1c;
			dx_q    <= x1c - x0c;
			dyn_q   <= y1c < y0c;
			steep_q <= steep;
			inten_q <= request.intensity;
			num_q   <= DIV_W'({ady, {F{1'b0}}});
			quo_q   <= '0;
			rem_q   <= '0;
			dcnt_q  <= '0;
		end
		if (cmd.div_step) begin
			num_q  <= num_q << 2;
			quo_q  <= {quo_q[DIV_W-3:0], ge1, ge2};
			rem_q  <= r2s[C-1:0];
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
		if (cmd.emit_first) begin
			acc_q <= ACC_W'({y0_q, {F{1'b0}}}) + grad;
			col_q <= C'(1);
		end
		if (cmd.emit_mid) begin
			acc_q <= acc_q + grad;
			col_q <= col_q + C'(1);
		end
		if (cmd.emit_first) begin
			res_q.pixel_a      <= PIX_A_W'(steep_q ? y0_q : x0_q);
			res_q.pixel_b      <= PIX_B_W'(steep_q ? x0_q : y0_q);
			res_q.pair_along_a <= steep_q;
			res_q.near_level   <= inten_q >> 1;
			res_q.far_level    <= '0;
			res_q.last         <= 1'b0;
		end else if (cmd.emit_mid) begin
			res_q.pixel_a      <= PIX_A_W'(steep_q ? minor : major);
			res_q.pixel_b      <= PIX_B_W'(steep_q ? major : minor);
			res_q.pair_along_a <= steep_q;
			res_q.near_level   <= near_prod[F+LEVEL_W-1:F];
			res_q.far_level    <= far_prod[F+LEVEL_W-1:F];
			res_q.last         <= 1'b0;
		end else if (cmd.emit_last) begin
			res_q.pixel_a      <= PIX_A_W'(steep_q ? y1_q : x1_q);
			res_q.pixel_b      <= PIX_B_W'(steep_q ? x1_q : y1_q);
			res_q.pair_along_a <= steep_q;
			res_q.near_level   <= inten_q >> 1;
			res_q.far_level    <= '0;
			res_q.last         <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit_first | cmd.emit_mid | cmd.emit_last;
		end
	end

	assign sts.div_last = dcnt_q == DCNT_W'(DIV_STEPS - 1);
	assign sts.dx_small = dx_q <= C'(1);
	assign sts.mid_last = col_q == dx_q - C'(1);

	assign result       = res_q;
	assign result_valid = valid_q;

	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !res_q.last |=> valid_q)
		else $error("result run broken before last item");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.last |=> !valid_q)
		else $error("result after last item of a line");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !valid_q)
		else $error("result strobe right after line load");

endmodule

// ===== sv/antialiased_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer
// Wu anti-aliased line walker: one pixel pair with coverage per major column.
// ----------------------------------------------------------------------------
// A line item is taken when start is high and busy is low.
// The work after that:
//   - Radix-4 gradient division.
//   - A step that forms the first endpoint.
//   - One pixel pair per cycle on result, marked by result_valid.
// The first pair is shown after the division and the first endpoint step, and
// the run ends with last set. The next line can be taken once busy is low.
// Results are not held, so the receiver must take each one in the cycle it is
// shown. busy stays high until the final pair of a line is formed, and drops
// in the cycle that pair is shown.
module antialiased_line_rasterizer import alr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t request,
	output logic busy,
	output res_t result,
	output logic result_valid
);

	cmd_t cmd;
	sts_t sts;

	alr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	alr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.request      (request),
		.cmd          (cmd),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
